[design/svf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svf_pkg;

  // Field and register widths
  localparam int SAMPLE_W        = 19;
  localparam int OUT_W           = 32;
  localparam int CUTOFF_W        = 13;
  localparam int RES_W           = 5;
  localparam int QD_W            = 8;
  localparam int K_W             = 10;
  localparam int SHIFT_W         = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = CUTOFF_W;
  localparam int STATE_WIDTH_DEF = 32;

  // Cutoff decode
  localparam logic [CUTOFF_W-1:0] K_FULL_CODE = 13'h1FFE;
  localparam logic [K_W-1:0]      K_BASE      = 10'd256;
  localparam logic [K_W-1:0]      K_FULL      = 10'd512;
  localparam logic [SHIFT_W-1:0]  SHIFT_BASE  = 5'd24;

  // High term clamp bounds, signed 24 bits
  localparam logic signed [23:0] CLAMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CLAMP_MIN = -24'sh800000;

  // Output saturation bounds
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -32'sh80000000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF    = 2'd0,
    CFG_RESONANCE = 2'd1,
    CFG_CLAMP     = 2'd2
  } cfg_idx_t;

  // Damping factor per resonance index, least resonant first
  function automatic logic [QD_W-1:0] damp_lookup(input logic [RES_W-1:0] idx);
    logic [QD_W-1:0] qd;
    case (idx)
      5'd0:    qd = 8'd192;
      5'd1:    qd = 8'd176;
      5'd2:    qd = 8'd160;
      5'd3:    qd = 8'd144;
      5'd4:    qd = 8'd128;
      5'd5:    qd = 8'd120;
      5'd6:    qd = 8'd112;
      5'd7:    qd = 8'd104;
      5'd8:    qd = 8'd96;
      5'd9:    qd = 8'd88;
      5'd10:   qd = 8'd80;
      5'd11:   qd = 8'd72;
      5'd12:   qd = 8'd64;
      5'd13:   qd = 8'd60;
      5'd14:   qd = 8'd56;
      5'd15:   qd = 8'd52;
      5'd16:   qd = 8'd48;
      5'd17:   qd = 8'd44;
      5'd18:   qd = 8'd40;
      5'd19:   qd = 8'd36;
      5'd20:   qd = 8'd32;
      5'd21:   qd = 8'd30;
      5'd22:   qd = 8'd28;
      5'd23:   qd = 8'd26;
      5'd24:   qd = 8'd24;
      5'd25:   qd = 8'd22;
      5'd26:   qd = 8'd20;
      5'd27:   qd = 8'd18;
      5'd28:   qd = 8'd16;
      5'd29:   qd = 8'd15;
      5'd30:   qd = 8'd14;
      5'd31:   qd = 8'd13;
      default: qd = 8'd192;
    endcase
    return qd;
  endfunction

endpackage

`default_nettype wire

[design/state_variable_filter_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-integrator state variable filter, one signed sample per transaction, giving the
// low-pass, band-pass and high-pass values of that step. One multiplier is shared by
// the three dependent products of a step (damping, band update, low update), each
// followed by an add-and-saturate step; the input stays stalled from the accepted
// sample until its result is registered, so a new sample is taken only back in idle.
// A new sample is accepted while the previous result still sits in the output
// register; if that result is still stalled when the new sample reaches its last
// step, the new sample waits there for as long as the stall lasts. Configuration
// writes are always ready and take effect from the next cycle, so write them only
// while no sample is in flight. STATE_WIDTH sets the integrator width; outputs are
// saturated to 32 bits.
module state_variable_filter_step #(
  parameter int STATE_WIDTH = svf_pkg::STATE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input sample channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [svf_pkg::SAMPLE_W-1:0] in_sample_in,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [svf_pkg::OUT_W-1:0]         out_low_out,
  output logic signed [svf_pkg::OUT_W-1:0]         out_band_out,
  output logic signed [svf_pkg::OUT_W-1:0]         out_high_out,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import svf_pkg::*;

  localparam int SW = STATE_WIDTH;
  localparam int AW = SW + 3;      // high term width
  localparam int BW = K_W + 1;     // signed coefficient width
  localparam int PW = AW + BW;     // product width

  localparam logic signed [PW-1:0] S_MAX = PW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [PW-1:0] S_MIN = -S_MAX - PW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAMP,
    ST_HIGH,
    ST_MULH,
    ST_BAND,
    ST_MULB,
    ST_LOW
  } state_t;

  state_t                      state_r, state_nxt;
  logic signed [SAMPLE_W-1:0]  x_r, x_nxt;
  logic signed [AW-1:0]        h_r, h_nxt;
  logic signed [PW-1:0]        p_r, p_nxt;
  logic signed [SW-1:0]        band_r, band_nxt;
  logic signed [SW-1:0]        low_r, low_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]     out_low_r, out_low_nxt;
  logic signed [OUT_W-1:0]     out_band_r, out_band_nxt;
  logic signed [OUT_W-1:0]     out_high_r, out_high_nxt;
  logic [CUTOFF_W-1:0]         cutoff_r, cutoff_nxt;
  logic [RES_W-1:0]            res_r, res_nxt;
  logic                        clamp_r, clamp_nxt;

  logic [K_W-1:0]              k;
  logic [SHIFT_W-1:0]          shift;
  logic [QD_W-1:0]             qd;
  logic signed [AW-1:0]        mul_a;
  logic signed [BW-1:0]        mul_b;
  logic signed [PW-1:0]        mul_p;
  logic signed [PW-1:0]        d_term;
  logic signed [PW-1:0]        h_full;
  logic signed [PW-1:0]        h_lim;
  logic signed [PW-1:0]        ceil_mask;
  logic signed [PW-1:0]        band_sum;
  logic signed [PW-1:0]        low_sum;
  logic signed [SW-1:0]        low_new;
  logic                        in_accept;
  logic                        out_free;

  // Saturate a product-width value to the integrator width
  function automatic logic signed [SW-1:0] sat_state(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v;
    if (v > S_MAX) t = S_MAX;
    else if (v < S_MIN) t = S_MIN;
    return SW'(t);
  endfunction

  // Saturate a product-width value to the output width
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v;
    if (v > PW'(OUT_MAX)) t = PW'(OUT_MAX);
    else if (v < PW'(OUT_MIN)) t = PW'(OUT_MIN);
    return OUT_W'(t);
  endfunction

  // Decode cutoff and resonance
  assign k     = (cutoff_r >= K_FULL_CODE) ? K_FULL : (K_BASE + K_W'(cutoff_r[8:1]));
  assign shift = SHIFT_BASE - {1'b0, cutoff_r[12:9]};
  assign qd    = damp_lookup(res_r);

  // Shared multiplier operand select
  always_comb begin
    mul_a = AW'(band_r);
    mul_b = BW'({3'b000, qd});
    case (state_r)
      ST_DAMP: begin
        mul_a = AW'(band_r);
        mul_b = BW'({3'b000, qd});
      end
      ST_MULH: begin
        mul_a = h_r;
        mul_b = BW'({1'b0, k});
      end
      ST_MULB: begin
        mul_a = AW'(band_r);
        mul_b = BW'({1'b0, k});
      end
      default: begin
        mul_a = AW'(band_r);
        mul_b = BW'({3'b000, qd});
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Damping rounded up, then high term with optional clamp
  assign d_term = ((p_r + PW'(255)) >>> 8) <<< 1;
  assign h_full = PW'(x_r) - PW'(low_r) - d_term;

  always_comb begin
    h_lim = h_full;
    if (clamp_r) begin
      if (h_full > PW'(CLAMP_MAX)) h_lim = PW'(CLAMP_MAX);
      else if (h_full < PW'(CLAMP_MIN)) h_lim = PW'(CLAMP_MIN);
    end
  end

  // Integrator updates: band rounds down, low rounds up
  assign ceil_mask = (PW'(1) << shift) - PW'(1);
  assign band_sum  = PW'(band_r) + (p_r >>> shift);
  assign low_sum   = PW'(low_r) + ((p_r + ceil_mask) >>> shift);
  assign low_new   = sat_state(low_sum);

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !(out_valid_r && out_stall);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    h_nxt         = h_r;
    p_nxt         = p_r;
    band_nxt      = band_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_low_nxt   = out_low_r;
    out_band_nxt  = out_band_r;
    out_high_nxt  = out_high_r;
    cutoff_nxt    = cutoff_r;
    res_nxt       = res_r;
    clamp_nxt     = clamp_r;

    // take configuration writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CUTOFF:    cutoff_nxt = cfg_data[CUTOFF_W-1:0];
        CFG_RESONANCE: res_nxt    = cfg_data[RES_W-1:0];
        CFG_CLAMP:     clamp_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          x_nxt     = in_sample_in;
          state_nxt = ST_DAMP;
        end
      end
      ST_DAMP: begin
        p_nxt     = mul_p;
        state_nxt = ST_HIGH;
      end
      ST_HIGH: begin
        h_nxt     = AW'(h_lim);
        state_nxt = ST_MULH;
      end
      ST_MULH: begin
        p_nxt     = mul_p;
        state_nxt = ST_BAND;
      end
      ST_BAND: begin
        band_nxt  = sat_state(band_sum);
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        p_nxt     = mul_p;
        state_nxt = ST_LOW;
      end
      ST_LOW: begin
        // hold until the output register is free
        if (out_free) begin
          low_nxt       = low_new;
          out_valid_nxt = 1'b1;
          out_low_nxt   = sat_out(PW'(low_new));
          out_band_nxt  = sat_out(PW'(band_r));
          out_high_nxt  = sat_out(PW'(h_r));
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, integrators, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      band_r      <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
      cutoff_r    <= '0;
      res_r       <= '0;
      clamp_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      band_r      <= band_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
      cutoff_r    <= cutoff_nxt;
      res_r       <= res_nxt;
      clamp_r     <= clamp_nxt;
    end
    x_r        <= x_nxt;
    h_r        <= h_nxt;
    p_r        <= p_nxt;
    out_low_r  <= out_low_nxt;
    out_band_r <= out_band_nxt;
    out_high_r <= out_high_nxt;
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_low_out  = out_low_r;
  assign out_band_out = out_band_r;
  assign out_high_out = out_high_r;
  assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

[design/svf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module svf_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [svf_pkg::OUT_W-1:0]    out_low_out,
  input wire logic signed [svf_pkg::OUT_W-1:0]    out_band_out,
  input wire logic signed [svf_pkg::OUT_W-1:0]    out_high_out
);
  import svf_pkg::*;

  // busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted transaction");

  // a sample passes through ST_DAMP and then ST_HIGH, so the input is still stalled in ST_HIGH
  a_busy_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 in_stall)
    else $error("sample finished too early");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_low_out) &&
                                  $stable(out_band_out) && $stable(out_high_out)))
    else $error("stalled result dropped or changed");

  // no result and input not stalled right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind state_variable_filter_step svf_checker u_svf_checker (.*);

`default_nettype wire
